[rtl/nrmc_pkg.sv]
// ----------------------------------------------------------------------------
// nrmc_pkg
// Shared constants, character codes and the result record type of the
// recommended-minimum GPS sentence parser.
// ----------------------------------------------------------------------------
package nrmc_pkg;

    localparam int MAX_DIGITS = 18;

    localparam int CHAR_W   = 8;
    localparam int ID_W     = 4;
    localparam int VALUE_W  = 60;
    localparam int COUNT_W  = 5;
    localparam int HEX_W    = 2;
    localparam int OUT_W    = 72;
    localparam int OUT_PAD_W = OUT_W - (VALUE_W + COUNT_W + 3);

    // Saturation value: MAX_DIGITS nines
    localparam logic [63:0] SAT_WIDE = (64'd10 ** MAX_DIGITS) - 64'd1;
    localparam logic [VALUE_W-1:0] SAT_VALUE = SAT_WIDE[VALUE_W-1:0];

    localparam logic [COUNT_W-1:0] MAX_DIGITS_C  = COUNT_W'(MAX_DIGITS);
    localparam logic [COUNT_W-1:0] HM_DIGITS     = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] HOUR_DIGITS   = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] DATE_DIGITS   = COUNT_W'(6);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;

    // Field positions, counted by commas after the address
    localparam logic [ID_W-1:0] FLD_TIME    = 4'd1;
    localparam logic [ID_W-1:0] FLD_STATUS  = 4'd2;
    localparam logic [ID_W-1:0] FLD_LAT     = 4'd3;
    localparam logic [ID_W-1:0] FLD_NS      = 4'd4;
    localparam logic [ID_W-1:0] FLD_LON     = 4'd5;
    localparam logic [ID_W-1:0] FLD_EW      = 4'd6;
    localparam logic [ID_W-1:0] FLD_SPEED   = 4'd7;
    localparam logic [ID_W-1:0] FLD_COURSE  = 4'd8;
    localparam logic [ID_W-1:0] FLD_DATE    = 4'd9;
    localparam logic [ID_W-1:0] FLD_MODE    = 4'd12;
    localparam logic [ID_W-1:0] FLD_NAVSTAT = 4'd13;
    localparam logic [ID_W-1:0] FLD_MAX     = 4'd15;

    // Result identifiers
    localparam logic [ID_W-1:0] ID_HOURS    = 4'd0;
    localparam logic [ID_W-1:0] ID_MINUTES  = 4'd1;
    localparam logic [ID_W-1:0] ID_SECONDS  = 4'd2;
    localparam logic [ID_W-1:0] ID_DAY      = 4'd10;
    localparam logic [ID_W-1:0] ID_MONTH    = 4'd11;
    localparam logic [ID_W-1:0] ID_YEAR     = 4'd12;
    localparam logic [ID_W-1:0] ID_CHECKSUM = 4'd15;

    typedef struct packed {
        logic [ID_W-1:0]    field_id;
        logic [VALUE_W-1:0] field_value;
        logic [COUNT_W-1:0] frac_digits;
        logic               is_empty;
        logic               overflowed;
        logic               checksum_ok;
        logic               last;
    } nrmc_result_t;

endpackage

[rtl/nmea_rmc_sentence_parser.sv]
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser
// Streaming parser for recommended-minimum GPS sentences, one byte per beat.
// ----------------------------------------------------------------------------
// The block takes one ASCII byte per clock cycle while its skid stage is free,
// and returns at most one result per byte. A byte is held in the input
// register, and its result is then registered in the output register, or in
// the skid stage while the output is stalled. Each byte passes once through
// a short decode between the input register and the sentence state; the
// longest path is the 60-bit multiply-by-ten accumulate of a digit. The
// output register has a skid stage behind it, so one result can wait while
// the next byte is still taken. No clearing pass follows reset. A
// result beat carries the field value, its fraction digit count and the empty,
// overflow and checksum flags in tdata, the field identifier in tuser, and
// tlast on the checksum record that closes each sentence.
module nmea_rmc_sentence_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [nrmc_pkg::CHAR_W-1:0]     s_axis_tdata,   // [7:0] char_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [59:0] field_value, [64:60] frac_digits, [65] is_empty,
    // [66] overflowed, [67] checksum_ok, [71:68] zero
    output logic [nrmc_pkg::OUT_W-1:0]      m_axis_tdata,
    output logic [nrmc_pkg::ID_W-1:0]       m_axis_tuser,   // [3:0] field_id
    output logic                            m_axis_tlast
);

    logic                           char_valid_reg;
    logic [nrmc_pkg::CHAR_W-1:0]    char_reg;
    logic                           core_ready;
    logic                           adv;
    logic                           res_valid;
    nrmc_pkg::nrmc_result_t         res;
    nrmc_pkg::nrmc_result_t         out_res;

    assign adv           = char_valid_reg && core_ready;
    assign s_axis_tready = !char_valid_reg || adv;

    // input register: hold a byte until the parser advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            char_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            char_reg <= s_axis_tdata;
        end
    end

    nrmc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .char_in   (char_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    nrmc_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (adv && res_valid),
        .in_ready  (core_ready),
        .in_data   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = {{nrmc_pkg::OUT_PAD_W{1'b0}}, out_res.checksum_ok,
                           out_res.overflowed, out_res.is_empty,
                           out_res.frac_digits, out_res.field_value};
    assign m_axis_tuser = out_res.field_id;
    assign m_axis_tlast = out_res.last;

endmodule

[rtl/nrmc_core.sv]
// ----------------------------------------------------------------------------
// nrmc_core
// Sentence state and single-pass decode of one byte into at most one result.
// ----------------------------------------------------------------------------
module nrmc_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic [nrmc_pkg::CHAR_W-1:0]      char_in,
    output logic                             res_valid,
    output nrmc_pkg::nrmc_result_t           res
);

    logic                            in_sentence_reg, in_sentence_next;
    logic [nrmc_pkg::ID_W-1:0]       field_index_reg, field_index_next;
    logic [nrmc_pkg::VALUE_W-1:0]    digit_accum_reg, digit_accum_next;
    logic [nrmc_pkg::COUNT_W-1:0]    digit_count_reg, digit_count_next;
    logic [nrmc_pkg::COUNT_W-1:0]    frac_count_reg, frac_count_next;
    logic                            point_seen_reg, point_seen_next;
    logic [nrmc_pkg::CHAR_W-1:0]     char_hold_reg, char_hold_next;
    logic [nrmc_pkg::CHAR_W-1:0]     running_xor_reg, running_xor_next;
    logic                            in_checksum_reg, in_checksum_next;
    logic [nrmc_pkg::CHAR_W-1:0]     rx_checksum_reg, rx_checksum_next;
    logic [nrmc_pkg::HEX_W-1:0]      hex_count_reg, hex_count_next;
    logic                            overflow_flag_reg, overflow_flag_next;

    logic                            is_digit;
    logic                            is_hex;
    logic [3:0]                      digit;
    logic [3:0]                      hex_val;
    logic [nrmc_pkg::CHAR_W-1:0]     rx_shift;
    logic [nrmc_pkg::VALUE_W-1:0]    accum_x10;
    logic [nrmc_pkg::COUNT_W-1:0]    count_inc;
    logic [nrmc_pkg::COUNT_W-1:0]    count_plus;
    logic [nrmc_pkg::COUNT_W-1:0]    frac_inc;
    logic [nrmc_pkg::COUNT_W-1:0]    take_used;
    logic [nrmc_pkg::ID_W-1:0]       field_plus;
    logic                            end_valid;
    nrmc_pkg::nrmc_result_t          end_res;
    logic                            clear_field;
    logic                            clear_all;
    logic                            start;

    assign is_digit = (char_in >= nrmc_pkg::CH_ZERO) && (char_in <= nrmc_pkg::CH_NINE);
    assign digit    = char_in[3:0];
    assign is_hex   = is_digit
                   || ((char_in >= nrmc_pkg::CH_UPPER_A) && (char_in <= nrmc_pkg::CH_UPPER_F))
                   || ((char_in >= nrmc_pkg::CH_LOWER_A) && (char_in <= nrmc_pkg::CH_LOWER_F));
    // letters A-F and a-f share low nibbles 1..6
    assign hex_val  = is_digit ? char_in[3:0] : char_in[3:0] + 4'd9;
    assign rx_shift = {rx_checksum_reg[3:0], hex_val};

    // x*10 + d as two shifted copies and two adds
    assign accum_x10 = (digit_accum_reg << 3) + (digit_accum_reg << 1)
                     + nrmc_pkg::VALUE_W'(digit);
    assign count_plus = digit_count_reg + 5'd1;
    assign count_inc  = (digit_count_reg == '1) ? digit_count_reg : count_plus;
    assign frac_inc   = (frac_count_reg == '1) ? frac_count_reg : frac_count_reg + 5'd1;
    assign take_used  = (field_index_reg == nrmc_pkg::FLD_TIME)
                      ? digit_count_reg - nrmc_pkg::HM_DIGITS : digit_count_reg;
    assign field_plus = field_index_reg + 4'd1;

    // Result, if any, for the field that ends on ',' or '*'
    always_comb
    begin
        end_valid = 1'b0;
        end_res   = '0;
        case (field_index_reg)
            nrmc_pkg::FLD_TIME:
            begin
                end_valid            = 1'b1;
                end_res.field_id     = nrmc_pkg::ID_SECONDS;
                end_res.field_value  = (digit_count_reg > nrmc_pkg::HM_DIGITS)
                                     ? digit_accum_reg : '0;
                end_res.frac_digits  = frac_count_reg;
                end_res.is_empty     = !(digit_count_reg > nrmc_pkg::HM_DIGITS)
                                     && !point_seen_reg;
                end_res.overflowed   = overflow_flag_reg;
            end
            nrmc_pkg::FLD_STATUS, nrmc_pkg::FLD_NS, nrmc_pkg::FLD_EW,
            nrmc_pkg::FLD_MODE, nrmc_pkg::FLD_NAVSTAT:
            begin
                // result ids of these fields sit one above their position
                end_valid            = 1'b1;
                end_res.field_id     = field_plus;
                end_res.field_value  = nrmc_pkg::VALUE_W'(char_hold_reg);
                end_res.is_empty     = (digit_count_reg == '0);
            end
            nrmc_pkg::FLD_LAT, nrmc_pkg::FLD_LON, nrmc_pkg::FLD_SPEED,
            nrmc_pkg::FLD_COURSE:
            begin
                end_valid            = 1'b1;
                end_res.field_id     = field_plus;
                end_res.field_value  = digit_accum_reg;
                end_res.frac_digits  = frac_count_reg;
                end_res.is_empty     = (digit_count_reg == '0) && !point_seen_reg;
                end_res.overflowed   = overflow_flag_reg;
            end
            default:
            begin
                end_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        in_sentence_next   = in_sentence_reg;
        field_index_next   = field_index_reg;
        digit_accum_next   = digit_accum_reg;
        digit_count_next   = digit_count_reg;
        frac_count_next    = frac_count_reg;
        point_seen_next    = point_seen_reg;
        char_hold_next     = char_hold_reg;
        running_xor_next   = running_xor_reg;
        in_checksum_next   = in_checksum_reg;
        rx_checksum_next   = rx_checksum_reg;
        hex_count_next     = hex_count_reg;
        overflow_flag_next = overflow_flag_reg;
        res_valid          = 1'b0;
        res                = '0;
        clear_field        = 1'b0;
        clear_all          = 1'b0;
        start              = 1'b0;

        if (adv)
        begin
            if (char_in == nrmc_pkg::CH_DOLLAR)
            begin
                clear_all = 1'b1;
                start     = 1'b1;
            end
            else if (in_sentence_reg)
            begin
                if (in_checksum_reg)
                begin
                    if (is_hex && (hex_count_reg == '0))
                    begin
                        rx_checksum_next = rx_shift;
                        hex_count_next   = 2'd1;
                    end
                    else
                    begin
                        // second digit or a bad byte closes the sentence
                        res_valid         = 1'b1;
                        res.field_id      = nrmc_pkg::ID_CHECKSUM;
                        res.last          = 1'b1;
                        if (is_hex)
                        begin
                            res.field_value = nrmc_pkg::VALUE_W'(rx_shift);
                            res.checksum_ok = (rx_shift == running_xor_reg);
                        end
                        else
                        begin
                            res.field_value = nrmc_pkg::VALUE_W'(rx_checksum_reg);
                            res.is_empty    = (hex_count_reg == '0);
                        end
                        clear_all = 1'b1;
                    end
                end
                else if (char_in == nrmc_pkg::CH_STAR)
                begin
                    res_valid        = end_valid;
                    res              = end_res;
                    clear_field      = 1'b1;
                    in_checksum_next = 1'b1;
                    hex_count_next   = '0;
                    rx_checksum_next = '0;
                end
                else
                begin
                    running_xor_next = running_xor_reg ^ char_in;
                    if (char_in == nrmc_pkg::CH_COMMA)
                    begin
                        res_valid   = end_valid;
                        res         = end_res;
                        clear_field = 1'b1;
                        if (field_index_reg != nrmc_pkg::FLD_MAX)
                        begin
                            field_index_next = field_plus;
                        end
                    end
                    else
                    begin
                        case (field_index_reg)
                            nrmc_pkg::FLD_TIME, nrmc_pkg::FLD_LAT, nrmc_pkg::FLD_LON,
                            nrmc_pkg::FLD_SPEED, nrmc_pkg::FLD_COURSE:
                            begin
                                if (char_in == nrmc_pkg::CH_POINT)
                                begin
                                    point_seen_next = 1'b1;
                                end
                                else if (is_digit && (field_index_reg == nrmc_pkg::FLD_TIME)
                                         && (digit_count_reg < nrmc_pkg::HM_DIGITS))
                                begin
                                    // hours and minutes
                                    digit_accum_next = accum_x10;
                                    digit_count_next = count_plus;
                                    if ((count_plus == nrmc_pkg::HOUR_DIGITS)
                                        || (count_plus == nrmc_pkg::HM_DIGITS))
                                    begin
                                        res_valid        = 1'b1;
                                        res.field_id     = (count_plus == nrmc_pkg::HOUR_DIGITS)
                                                         ? nrmc_pkg::ID_HOURS
                                                         : nrmc_pkg::ID_MINUTES;
                                        res.field_value  = accum_x10;
                                        digit_accum_next = '0;
                                    end
                                end
                                else if (is_digit)
                                begin
                                    if (take_used >= nrmc_pkg::MAX_DIGITS_C)
                                    begin
                                        overflow_flag_next = 1'b1;
                                        digit_accum_next   = nrmc_pkg::SAT_VALUE;
                                    end
                                    else
                                    begin
                                        digit_accum_next = accum_x10;
                                        digit_count_next = count_inc;
                                        if (point_seen_reg)
                                        begin
                                            frac_count_next = frac_inc;
                                        end
                                    end
                                end
                            end
                            nrmc_pkg::FLD_DATE:
                            begin
                                if (is_digit && (digit_count_reg < nrmc_pkg::DATE_DIGITS))
                                begin
                                    digit_accum_next = accum_x10;
                                    digit_count_next = count_plus;
                                    if (!count_plus[0])
                                    begin
                                        res_valid        = 1'b1;
                                        res.field_value  = accum_x10;
                                        digit_accum_next = '0;
                                        if (count_plus == nrmc_pkg::HOUR_DIGITS)
                                        begin
                                            res.field_id = nrmc_pkg::ID_DAY;
                                        end
                                        else if (count_plus == nrmc_pkg::HM_DIGITS)
                                        begin
                                            res.field_id = nrmc_pkg::ID_MONTH;
                                        end
                                        else
                                        begin
                                            res.field_id = nrmc_pkg::ID_YEAR;
                                        end
                                    end
                                end
                            end
                            nrmc_pkg::FLD_STATUS, nrmc_pkg::FLD_NS, nrmc_pkg::FLD_EW,
                            nrmc_pkg::FLD_MODE, nrmc_pkg::FLD_NAVSTAT:
                            begin
                                // keep the first byte only
                                if (digit_count_reg == '0)
                                begin
                                    char_hold_next = char_in;
                                end
                                digit_count_next = count_inc;
                            end
                            default:
                            begin
                                digit_count_next = digit_count_reg;
                            end
                        endcase
                    end
                end
            end
        end

        if (clear_field || clear_all)
        begin
            digit_accum_next   = '0;
            digit_count_next   = '0;
            frac_count_next    = '0;
            point_seen_next    = 1'b0;
            char_hold_next     = '0;
            overflow_flag_next = 1'b0;
        end
        if (clear_all)
        begin
            in_sentence_next = 1'b0;
            field_index_next = '0;
            running_xor_next = '0;
            in_checksum_next = 1'b0;
            rx_checksum_next = '0;
            hex_count_next   = '0;
        end
        if (start)
        begin
            in_sentence_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg   <= 1'b0;
            field_index_reg   <= '0;
            digit_accum_reg   <= '0;
            digit_count_reg   <= '0;
            frac_count_reg    <= '0;
            point_seen_reg    <= 1'b0;
            char_hold_reg     <= '0;
            running_xor_reg   <= '0;
            in_checksum_reg   <= 1'b0;
            rx_checksum_reg   <= '0;
            hex_count_reg     <= '0;
            overflow_flag_reg <= 1'b0;
        end
        else
        begin
            in_sentence_reg   <= in_sentence_next;
            field_index_reg   <= field_index_next;
            digit_accum_reg   <= digit_accum_next;
            digit_count_reg   <= digit_count_next;
            frac_count_reg    <= frac_count_next;
            point_seen_reg    <= point_seen_next;
            char_hold_reg     <= char_hold_next;
            running_xor_reg   <= running_xor_next;
            in_checksum_reg   <= in_checksum_next;
            rx_checksum_reg   <= rx_checksum_next;
            hex_count_reg     <= hex_count_next;
            overflow_flag_reg <= overflow_flag_next;
        end
    end

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !in_sentence_reg |-> (!in_checksum_reg && (field_index_reg == '0)))
        else $error("field state left over outside a sentence");

    a_hex_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_checksum_reg |-> (hex_count_reg <= 2'd1))
        else $error("checksum digit count out of range");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (char_in == nrmc_pkg::CH_DOLLAR)) |=>
            (in_sentence_reg && !in_checksum_reg && (field_index_reg == '0)))
        else $error("sentence start did not reset the parser");

endmodule

[rtl/nrmc_skid.sv]
// ----------------------------------------------------------------------------
// nrmc_skid
// Output register with a skid stage so the parser can still hand over one more
// result after the downstream side stalls.
// ----------------------------------------------------------------------------
module nrmc_skid (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  nrmc_pkg::nrmc_result_t  in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output nrmc_pkg::nrmc_result_t  out_data
);

    logic                   out_valid_reg;
    nrmc_pkg::nrmc_result_t out_data_reg;
    logic                   skid_valid_reg;
    nrmc_pkg::nrmc_result_t skid_data_reg;
    logic                   push;
    logic                   out_free;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (push)
        begin
            skid_data_reg <= in_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a beat while the output register is empty");

endmodule
